// ===== rtl/clur_pkg.sv =====
// Shared constants and types of the camera line unpack and reorder block.
`timescale 1ns / 1ps
package clur_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Result queue depth; a power of two so the pointers wrap naturally.
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_PACK_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [1:0] PHASE_W0 = 2'd0;
    localparam logic [1:0] PHASE_W1 = 2'd1;
    localparam logic [1:0] PHASE_W2 = 2'd2;

    typedef struct packed {
        logic        frame_end;
        logic        run_end;
        logic [11:0] out_column;
        logic [11:0] out_row;
        logic [15:0] pixel_high;
        logic [15:0] pixel_low;
    } result_t;

    // Position bookkeeping for one result.
    typedef struct packed {
        logic [11:0] row;
        logic [11:0] column;
        logic [11:0] next_column;
        logic [11:0] next_line;
        logic        frame_end;
    } place_t;

    // Queue status seen by the front end.
    typedef struct packed {
        logic room_for_two;
        logic not_empty;
    } queue_status_t;

endpackage

// ===== rtl/clur_result_queue.sv =====
// Small result queue that takes up to two results per cycle and returns one.
`timescale 1ns / 1ps
module clur_result_queue
    import clur_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    push_count,
    input  result_t       push_first,
    input  result_t       push_second,
    input  logic          pop,
    output result_t       head,
    output queue_status_t status
);

    result_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W:0]   free_slots;
    logic               do_pop;

    assign do_pop = pop && (count_reg != '0);

    // Room counts a slot that is being freed in this same cycle.
    assign free_slots = (COUNT_W+1)'(QUEUE_DEPTH) - {1'b0, count_reg}
                        + {{COUNT_W{1'b0}}, do_pop};

    assign status.room_for_two = free_slots >= (COUNT_W+1)'(2);
    assign status.not_empty    = count_reg != '0;
    assign head                = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + COUNT_W'(push_count) - COUNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_first;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push_count == 2'd2 && !do_pop) |=> (count_reg == $past(count_reg) + COUNT_W'(2)))
        else $error("double push lost an entry");

endmodule

// ===== rtl/camera_line_unpack_reorder_unit.sv =====
// Top level of the camera line unpack and reorder block.
`timescale 1ns / 1ps
// Usage
// The slave stream takes one 32-bit camera word per handshake. In packed
// mode each group of three words carries eight 12-bit pixels and yields
// four pixel-pair words on the master stream: one for the first word, one
// for the second and two for the third. In raw mode every word passes
// through as one pixel pair. Each output word carries the destination row
// (sensor lines arrive edge-interleaved), the column of its even pixel,
// a run-end flag on tlast and a frame-end flag on tuser.
// Each result is registered in the queue and leaves it in order. The
// input side takes a word in every cycle while the four-entry result
// queue has room for two results, so raw data flows at one word per
// cycle while the receiver does not stall, and packed data slower, set
// by the single-result master port. When the receiver stalls, results
// wait in the queue and s_tready drops once fewer than two slots are
// free. Reset empties the queue, clears the group phase, carried bits
// and column and line counters, and loads packed mode with 1024 by 1024
// pixels. Configuration is written through cfg_we, cfg_index and cfg_data
// by the user only while the block is idle; the block does not enforce it.
module camera_line_unpack_reorder_unit
    import clur_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // raw_word
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [55:0]            m_tdata,   // pixel_low, pixel_high, out_row, out_column
    output logic                   m_tlast,   // run_end
    output logic [0:0]             m_tuser    // frame_end
);

    logic        pack_mode_reg;
    logic [12:0] line_width_reg;
    logic [12:0] frame_height_reg;

    logic [1:0]  word_phase_reg;
    logic [1:0]  word_phase_next;
    logic [15:0] carry_bits_reg;
    logic [15:0] carry_bits_next;
    logic [11:0] column_count_reg;
    logic [11:0] column_count_next;
    logic [11:0] line_count_reg;
    logic [11:0] line_count_next;

    logic [12:0] width_clamped;
    logic [12:0] width_eff;
    logic [12:0] height_clamped;
    logic [12:0] height_eff;
    logic [12:0] last_line_wide;
    logic [11:0] last_line;

    logic          accept;
    logic [1:0]    phase;
    logic          two_results;
    logic [11:0]   lo_a;
    logic [11:0]   hi_a;
    logic [11:0]   lo_b;
    logic [11:0]   hi_b;
    place_t        place_a;
    place_t        place_b;
    result_t       res_a;
    result_t       res_b;
    logic [1:0]    push_count;
    result_t       head;
    queue_status_t q_status;
    logic          pop;

    // Derived frame geometry. The width is clamped, then rounded down to
    // whole groups (eight pixels packed, two raw) with a floor of one group.
    assign width_clamped  = (line_width_reg > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH)
                                                              : line_width_reg;
    assign height_clamped = (frame_height_reg > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT)
                                                                 : frame_height_reg;

    always_comb
    begin
        if (!pack_mode_reg)
        begin
            width_eff = {width_clamped[12:3], 3'b000};
            if (width_eff < 13'd8)
            begin
                width_eff = 13'd8;
            end
        end
        else
        begin
            width_eff = {width_clamped[12:1], 1'b0};
            if (width_eff < 13'd2)
            begin
                width_eff = 13'd2;
            end
        end
    end

    assign height_eff     = (height_clamped < 13'd2) ? 13'd2 : height_clamped;
    // Only an even number of lines is sent; an odd middle row stays empty.
    assign last_line_wide = {height_eff[12:1], 1'b0} - 13'd1;
    assign last_line      = last_line_wide[11:0];

    // Works out row and column of one result and the counters after it.
    // Even sensor lines fill rows from the top, odd ones from the bottom.
    function automatic place_t place_of(input logic [11:0] col,
                                        input logic [11:0] line,
                                        input logic [12:0] w,
                                        input logic [12:0] h,
                                        input logic [11:0] last);
        place_t      p;
        logic [11:0] k;
        logic [12:0] from_bottom;
        k           = (line > last) ? last : line;
        from_bottom = h - 13'd1 - {2'b00, k[11:1]};
        p.row       = k[0] ? from_bottom[11:0] : {1'b0, k[11:1]};
        p.column    = col;
        p.frame_end = 1'b0;
        if (({1'b0, col} + 13'd2) >= w)
        begin
            p.next_column = 12'd0;
            if (k >= last)
            begin
                p.next_line = 12'd0;
                p.frame_end = 1'b1;
            end
            else
            begin
                p.next_line = k + 12'd1;
            end
        end
        else
        begin
            p.next_column = col + 12'd2;
            p.next_line   = line;
        end
        return p;
    endfunction

    // Unpacking. A phase of three is treated as the start of a group.
    assign phase = (word_phase_reg == PHASE_W1 || word_phase_reg == PHASE_W2)
                   ? word_phase_reg : PHASE_W0;

    always_comb
    begin
        lo_a            = 12'd0;
        hi_a            = 12'd0;
        lo_b            = {s_tdata[7:0], s_tdata[31:28]};
        hi_b            = s_tdata[27:16];
        two_results     = 1'b0;
        carry_bits_next = carry_bits_reg;
        word_phase_next = PHASE_W0;
        if (!pack_mode_reg)
        begin
            case (phase)
                PHASE_W1:
                begin
                    lo_a            = {carry_bits_reg[7:0], s_tdata[15:12]};
                    hi_a            = s_tdata[11:0];
                    carry_bits_next = s_tdata[31:16];
                    word_phase_next = PHASE_W2;
                end
                PHASE_W2:
                begin
                    lo_a            = carry_bits_reg[15:4];
                    hi_a            = {carry_bits_reg[3:0], s_tdata[15:8]};
                    two_results     = 1'b1;
                    word_phase_next = PHASE_W0;
                end
                default:
                begin
                    lo_a            = s_tdata[15:4];
                    hi_a            = {s_tdata[3:0], s_tdata[31:24]};
                    carry_bits_next = s_tdata[31:16];
                    word_phase_next = PHASE_W1;
                end
            endcase
        end
    end

    assign place_a = place_of(column_count_reg, line_count_reg,
                              width_eff, height_eff, last_line);
    assign place_b = place_of(place_a.next_column, place_a.next_line,
                              width_eff, height_eff, last_line);

    always_comb
    begin
        res_a.pixel_low  = pack_mode_reg ? s_tdata[15:0]  : {4'd0, lo_a};
        res_a.pixel_high = pack_mode_reg ? s_tdata[31:16] : {4'd0, hi_a};
        res_a.out_row    = place_a.row;
        res_a.out_column = place_a.column;
        res_a.run_end    = !two_results;
        res_a.frame_end  = place_a.frame_end;

        res_b.pixel_low  = {4'd0, lo_b};
        res_b.pixel_high = {4'd0, hi_b};
        res_b.out_row    = place_b.row;
        res_b.out_column = place_b.column;
        res_b.run_end    = 1'b1;
        res_b.frame_end  = place_b.frame_end;
    end

    assign accept     = s_tvalid && s_tready;
    assign push_count = !accept ? 2'd0 : (two_results ? 2'd2 : 2'd1);

    always_comb
    begin
        column_count_next = column_count_reg;
        line_count_next   = line_count_reg;
        if (accept)
        begin
            column_count_next = two_results ? place_b.next_column : place_a.next_column;
            line_count_next   = two_results ? place_b.next_line   : place_a.next_line;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_mode_reg    <= 1'b0;
            line_width_reg   <= 13'd1024;
            frame_height_reg <= 13'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PACK_MODE:    pack_mode_reg    <= cfg_data[0];
                CFG_LINE_WIDTH:   line_width_reg   <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_phase_reg   <= PHASE_W0;
            carry_bits_reg   <= 16'd0;
            column_count_reg <= 12'd0;
            line_count_reg   <= 12'd0;
        end
        else
        begin
            if (accept)
            begin
                word_phase_reg <= word_phase_next;
                carry_bits_reg <= carry_bits_next;
            end
            column_count_reg <= column_count_next;
            line_count_reg   <= line_count_next;
        end
    end

    clur_result_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (push_count),
        .push_first  (res_a),
        .push_second (res_b),
        .pop         (pop),
        .head        (head),
        .status      (q_status)
    );

    assign pop      = m_tvalid && m_tready;
    assign s_tready = q_status.room_for_two;
    assign m_tvalid = q_status.not_empty;
    assign m_tdata  = {head.out_column, head.out_row, head.pixel_high, head.pixel_low};
    assign m_tlast  = head.run_end;
    assign m_tuser  = head.frame_end;

    assert property (@(posedge clk) disable iff (!rst_n)
        column_count_reg[0] == 1'b0)
        else $error("column counter is odd");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pack_mode_reg) |=> (word_phase_reg == PHASE_W0))
        else $error("raw word left a packed phase behind");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (two_results ? res_b.frame_end : res_a.frame_end))
        |=> (line_count_reg == 12'd0 && column_count_reg == 12'd0))
        else $error("counters did not wrap at frame end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && two_results) |-> (!pack_mode_reg && phase == PHASE_W2))
        else $error("two results outside the third packed word");

endmodule
